// ===== rtl/mme_pkg.sv =====
package mme_pkg;

   localparam int MAX_DIM   = 16;
   localparam int FRAC_BITS = 16;

   // widths fixed by the transaction fields
   localparam int IDX_W     = 4;
   localparam int VAL_W     = 32;
   localparam int DIMREG_W  = 5;
   localparam int CSR_IDX_W = 3;

   // dimension compares are done at a width that holds any MAX_DIM in range
   localparam int CMP_W     = 8;
   localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);
   localparam int ACC_W     = 64;
   localparam int PROD_W    = 96;

   localparam int REQ_DATA_W = ((2 * IDX_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * IDX_W + VAL_W + 7) / 8) * 8;
   localparam int REQ_USER_W = 2;

   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

   typedef enum logic [REQ_USER_W-1:0] {
      REQ_WR_A = 2'd0,
      REQ_WR_B = 2'd1,
      REQ_READ = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      CMD_WR_A,
      CMD_WR_B,
      CMD_READ,
      CMD_OOR
   } cmd_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUT_ROWS    = 3'd0,
      CSR_INNER_LEN   = 3'd1,
      CSR_OUT_COLS    = 3'd2,
      CSR_TRANS_A     = 3'd3,
      CSR_TRANS_B     = 3'd4,
      CSR_SCALE       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CMP_W-1:0]        rows;
      logic [CMP_W-1:0]        inner;
      logic [CMP_W-1:0]        cols;
      logic                    trans_a;
      logic                    trans_b;
      logic signed [VAL_W-1:0] scale;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [ADDR_W-1:0] addr;
      logic [VAL_W-1:0] value;
   } cmd_type;

   // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
   function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIMREG_W-1:0] d);
      logic [CMP_W-1:0] w;
      w = CMP_W'(d);
      if (w == '0) begin
         return CMP_W'(1);
      end
      if (w > CMP_W'(MAX_DIM)) begin
         return CMP_W'(MAX_DIM);
      end
      return w;
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [CMP_W-1:0] r,
                                                 input logic [CMP_W-1:0] c);
      logic [2*CMP_W-1:0] t;
      t = (2*CMP_W)'(r) * (2*CMP_W)'(MAX_DIM) + (2*CMP_W)'(c);
      return t[ADDR_W-1:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return s[ACC_W-1:0];
   endfunction

   function automatic logic [VAL_W-1:0] sat_val(input logic signed [PROD_W-1:0] q);
      logic [PROD_W-VAL_W:0] upper;
      upper = q[PROD_W-1:VAL_W-1];
      if ((&upper) || !(|upper)) begin
         return q[VAL_W-1:0];
      end
      return q[PROD_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
   endfunction

endpackage

// ===== rtl/mme_ram.sv =====
module mme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mme_queue.sv =====
module mme_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mme_pkg::cmd_type push_cmd,
   output logic             full,
   output logic             valid,
   output mme_pkg::cmd_type cmd,
   input  logic             pop
);

   mme_pkg::cmd_type               entry_ff [mme_pkg::QDEPTH];
   logic [mme_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mme_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mme_pkg::QPTR_W:0]       count_ff, count_in;
   logic                           do_push, do_pop;

   assign full    = (count_ff == (mme_pkg::QPTR_W+1)'(mme_pkg::QDEPTH));
   assign valid   = (count_ff != '0);
   assign cmd     = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == mme_pkg::QPTR_W'(mme_pkg::QDEPTH - 1)) ? '0
                     : wr_ptr_ff + mme_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == mme_pkg::QPTR_W'(mme_pkg::QDEPTH - 1)) ? '0
                     : rd_ptr_ff + mme_pkg::QPTR_W'(1);
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + (mme_pkg::QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (mme_pkg::QPTR_W+1)'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/mme_front.sv =====
module mme_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mme_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [mme_pkg::REQ_USER_W-1:0]    req_tuser,
   input  mme_pkg::cfg_type                  cfg,
   input  logic                              q_full,
   output logic                              push,
   output mme_pkg::cmd_type                  push_cmd
);

   logic [mme_pkg::IDX_W-1:0] row, col;
   logic [mme_pkg::VAL_W-1:0] value;
   logic                      in_store, out_of_range;

   assign row   = req_tdata[mme_pkg::IDX_W-1:0];
   assign col   = req_tdata[2*mme_pkg::IDX_W-1:mme_pkg::IDX_W];
   assign value = req_tdata[2*mme_pkg::IDX_W+mme_pkg::VAL_W-1:2*mme_pkg::IDX_W];

   assign req_tready = !q_full;

   assign in_store = (mme_pkg::CMP_W'(row) < mme_pkg::CMP_W'(mme_pkg::MAX_DIM))
                  && (mme_pkg::CMP_W'(col) < mme_pkg::CMP_W'(mme_pkg::MAX_DIM));
   assign out_of_range = (mme_pkg::CMP_W'(row) >= cfg.rows)
                      || (mme_pkg::CMP_W'(col) >= cfg.cols);

   always_comb begin
      push_cmd.row   = row;
      push_cmd.col   = col;
      push_cmd.value = value;
      push_cmd.addr  = mme_pkg::addr_of(mme_pkg::CMP_W'(row), mme_pkg::CMP_W'(col));
      push_cmd.kind  = mme_pkg::CMD_READ;
      push           = 1'b0;
      unique case (req_tuser)
         mme_pkg::REQ_WR_A: begin
            push_cmd.kind = mme_pkg::CMD_WR_A;
            push          = req_tvalid && !q_full && in_store;
         end
         mme_pkg::REQ_WR_B: begin
            push_cmd.kind = mme_pkg::CMD_WR_B;
            push          = req_tvalid && !q_full && in_store;
         end
         mme_pkg::REQ_READ: begin
            push_cmd.kind = out_of_range ? mme_pkg::CMD_OOR : mme_pkg::CMD_READ;
            push          = req_tvalid && !q_full;
         end
         default: begin
            // unused request code: taken and dropped
            push = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/mme_back.sv =====
module mme_back (
   input  logic                           clock,
   input  logic                           reset,
   input  mme_pkg::cfg_type               cfg,
   input  logic                           q_valid,
   input  mme_pkg::cmd_type               q_cmd,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mme_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_SCALE_LO,
      ST_SCALE_HI,
      ST_SUM,
      ST_SAT,
      ST_RESULT
   } state_type;

   state_type                          state_ff, state_in;
   logic [mme_pkg::CMP_W-1:0]          k_ff, k_in;
   logic [mme_pkg::IDX_W-1:0]          row_ff, row_in, col_ff, col_in;
   logic                               rd_vld_ff, rd_vld_in, rd_last_ff, rd_last_in;
   logic                               prod_vld_ff, prod_vld_in, prod_last_ff, prod_last_in;
   logic signed [2*mme_pkg::VAL_W-1:0] prod_ff, prod_in;
   logic signed [mme_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [mme_pkg::VAL_W*2:0]   pp_lo_ff, pp_lo_in;
   logic signed [mme_pkg::ACC_W-1:0]   pp_hi_ff, pp_hi_in;
   logic signed [mme_pkg::PROD_W-1:0]  full_ff, full_in;
   logic [mme_pkg::VAL_W-1:0]          res_product_ff, res_product_in;
   logic                               res_status_ff, res_status_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [mme_pkg::IDX_W-1:0]          rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [mme_pkg::VAL_W-1:0]          rsp_product_ff, rsp_product_in;
   logic                               rsp_status_ff, rsp_status_in;

   logic                               slot_free;
   logic                               wr_a, wr_b;
   logic [mme_pkg::ADDR_W-1:0]         rd_addr_a, rd_addr_b;
   logic [mme_pkg::VAL_W-1:0]          rdata_a, rdata_b;
   logic signed [mme_pkg::VAL_W:0]     lo_op;
   logic signed [mme_pkg::PROD_W-1:0]  shifted;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign wr_a      = q_pop && (q_cmd.kind == mme_pkg::CMD_WR_A);
   assign wr_b      = q_pop && (q_cmd.kind == mme_pkg::CMD_WR_B);

   assign rd_addr_a = cfg.trans_a
                      ? mme_pkg::addr_of(k_ff, mme_pkg::CMP_W'(row_ff))
                      : mme_pkg::addr_of(mme_pkg::CMP_W'(row_ff), k_ff);
   assign rd_addr_b = cfg.trans_b
                      ? mme_pkg::addr_of(mme_pkg::CMP_W'(col_ff), k_ff)
                      : mme_pkg::addr_of(k_ff, mme_pkg::CMP_W'(col_ff));

   mme_ram #(.WIDTH(mme_pkg::VAL_W), .DEPTH(mme_pkg::MAX_DIM * mme_pkg::MAX_DIM)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (q_cmd.addr),
      .wr_data (q_cmd.value),
      .rd_addr (rd_addr_a),
      .rd_data (rdata_a)
   );

   mme_ram #(.WIDTH(mme_pkg::VAL_W), .DEPTH(mme_pkg::MAX_DIM * mme_pkg::MAX_DIM)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (q_cmd.addr),
      .wr_data (q_cmd.value),
      .rd_addr (rd_addr_b),
      .rd_data (rdata_b)
   );

   assign lo_op   = $signed({1'b0, acc_ff[mme_pkg::VAL_W-1:0]});
   assign shifted = full_ff >>> mme_pkg::FRAC_BITS;

   always_comb begin
      state_in       = state_ff;
      k_in           = k_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      rd_vld_in      = 1'b0;
      rd_last_in     = 1'b0;
      prod_vld_in    = rd_vld_ff;
      prod_last_in   = rd_last_ff;
      prod_in        = $signed(rdata_a) * $signed(rdata_b);
      acc_in         = acc_ff;
      pp_lo_in       = pp_lo_ff;
      pp_hi_in       = pp_hi_ff;
      full_in        = full_ff;
      res_product_in = res_product_ff;
      res_status_in  = res_status_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_product_in = rsp_product_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      // multiply-accumulate stage, floor shift of each product
      if (prod_vld_ff) begin
         acc_in = mme_pkg::sat_add(acc_ff, prod_ff >>> mme_pkg::FRAC_BITS);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               row_in = q_cmd.row;
               col_in = q_cmd.col;
               if (q_cmd.kind == mme_pkg::CMD_READ) begin
                  k_in     = '0;
                  acc_in   = '0;
                  state_in = ST_MAC;
               end else if (q_cmd.kind == mme_pkg::CMD_OOR) begin
                  res_product_in = '0;
                  res_status_in  = 1'b1;
                  state_in       = ST_RESULT;
               end
            end
         end
         ST_MAC: begin
            rd_vld_in  = 1'b1;
            rd_last_in = (k_ff == cfg.inner - mme_pkg::CMP_W'(1));
            k_in       = k_ff + mme_pkg::CMP_W'(1);
            if (rd_last_in) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (prod_vld_ff && prod_last_ff) begin
               state_in = ST_SCALE_LO;
            end
         end
         ST_SCALE_LO: begin
            pp_lo_in = lo_op * cfg.scale;
            state_in = ST_SCALE_HI;
         end
         ST_SCALE_HI: begin
            pp_hi_in = $signed(acc_ff[mme_pkg::ACC_W-1:mme_pkg::VAL_W]) * cfg.scale;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            full_in  = (mme_pkg::PROD_W'(pp_hi_ff) <<< mme_pkg::VAL_W)
                       + mme_pkg::PROD_W'(pp_lo_ff);
            state_in = ST_SAT;
         end
         ST_SAT: begin
            res_product_in = mme_pkg::sat_val(shifted);
            res_status_in  = 1'b0;
            state_in       = ST_RESULT;
         end
         ST_RESULT: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_row_in     = row_ff;
               rsp_col_in     = col_ff;
               rsp_product_in = res_product_ff;
               rsp_status_in  = res_status_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff           <= k_in;
      row_ff         <= row_in;
      col_ff         <= col_in;
      rd_last_ff     <= rd_last_in;
      prod_last_ff   <= prod_last_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      pp_lo_ff       <= pp_lo_in;
      pp_hi_ff       <= pp_hi_in;
      full_ff        <= full_in;
      res_product_ff <= res_product_in;
      res_status_ff  <= res_status_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_product_ff <= rsp_product_in;
      rsp_status_ff  <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mme_pkg::RSP_DATA_W'({rsp_product_ff, rsp_col_ff, rsp_row_ff});
   assign rsp_tuser  = rsp_status_ff;

   // products only flow while a dot product is running
   a_prod_in_mac: assert property (@(posedge clock) disable iff (reset)
      prod_vld_ff |-> (state_ff == ST_MAC || state_ff == ST_DRAIN))
      else $error("product stage active outside dot product");

   // pipeline is empty once scaling starts
   a_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCALE_LO |-> (!prod_vld_ff && !rd_vld_ff))
      else $error("accumulator pipeline not drained before scaling");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && slot_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not moved to output register");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_product_ff == '0))
      else $error("out-of-range transaction with nonzero product");

endmodule

// ===== rtl/matrix_multiply_engine.sv =====
// scaled matrix product engine, C = scale * op(A) * op(B), Q16.16 operands
// req channel: tuser selects write A, write B or read of one C element;
// tdata carries row, col and the element value (ignored on reads).
// writes load the element stores and produce no response; writes outside
// the store and the unused request code are taken and dropped.
// rsp channel: one transaction per read, with row, col, the saturated
// element and a status flag (1 = index outside the configured size).
// csr port: plain write, index selects out_rows, inner_len, out_cols,
// the two transpose flags, scale_factor; write only while idle.
// a read holds the back end from the pop through the load of the output
// register: one multiply-accumulate per cycle through the store read
// ports, a drain of the product pipeline, two partial products for the
// scale, a sum and a saturation step; store reads issue at that rate.
// writes are stored at the pop; out-of-range reads skip to the result step.
// a two-entry queue sits between request decode and execution, so the
// front keeps taking transactions until the queue is full while the back end
// works or while a response waits in the output register for rsp_tready.
// reset clears the queue, the controller and the output register and
// restores the configuration defaults; store contents are undefined.
module matrix_multiply_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mme_pkg::REQ_DATA_W-1:0]      req_tdata,  // row, col, value
   input  logic [mme_pkg::REQ_USER_W-1:0]      req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mme_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // out_row, out_col, product
   output logic                                rsp_tuser,  // status
   input  logic                                csr_we,
   input  logic [mme_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [mme_pkg::VAL_W-1:0]           csr_wdata
);

   mme_pkg::cfg_type cfg_ff, cfg_in;
   logic             push, q_full, q_valid, q_pop;
   mme_pkg::cmd_type push_cmd, q_cmd;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            mme_pkg::CSR_OUT_ROWS:
               cfg_in.rows = mme_pkg::clamp_dim(csr_wdata[mme_pkg::DIMREG_W-1:0]);
            mme_pkg::CSR_INNER_LEN:
               cfg_in.inner = mme_pkg::clamp_dim(csr_wdata[mme_pkg::DIMREG_W-1:0]);
            mme_pkg::CSR_OUT_COLS:
               cfg_in.cols = mme_pkg::clamp_dim(csr_wdata[mme_pkg::DIMREG_W-1:0]);
            mme_pkg::CSR_TRANS_A:     cfg_in.trans_a = csr_wdata[0];
            mme_pkg::CSR_TRANS_B:     cfg_in.trans_b = csr_wdata[0];
            mme_pkg::CSR_SCALE:       cfg_in.scale   = $signed(csr_wdata);
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows    <= mme_pkg::clamp_dim(mme_pkg::DIMREG_W'(16));
         cfg_ff.inner   <= mme_pkg::clamp_dim(mme_pkg::DIMREG_W'(16));
         cfg_ff.cols    <= mme_pkg::clamp_dim(mme_pkg::DIMREG_W'(16));
         cfg_ff.trans_a <= 1'b0;
         cfg_ff.trans_b <= 1'b0;
         cfg_ff.scale   <= mme_pkg::VAL_W'(65536);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mme_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   mme_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .valid    (q_valid),
      .cmd      (q_cmd),
      .pop      (q_pop)
   );

   mme_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
